// ----- hw/rtl/wis_pkg.sv -----
// Package with types, constants, the state enum and the saturating add of the interval scheduling core.
`timescale 1ns / 1ps
package wis_pkg;
    localparam int MaxItems  = 128;
    localparam int AddrW     = $clog2(MaxItems);
    localparam int CountW    = $clog2(MaxItems + 1);
    localparam int MinuteW   = 11;
    localparam int GainW     = 16;
    localparam int BestW     = 23;
    localparam int EntryW    = 2 * MinuteW + GainW;
    localparam logic [BestW-1:0] BestSat = {BestW{1'b1}};

    typedef struct packed {
        logic [MinuteW-1:0] start_minute;
        logic [MinuteW-1:0] finish_minute;
        logic [GainW-1:0]   gain;
        logic               is_last;
    } t_in_beat;

    typedef struct packed {
        logic [BestW-1:0] max_gain;
        logic             dropped;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_DP_INIT,
        ST_DP_RD_I,
        ST_DP_LD_I,
        ST_DP_RD_J,
        ST_DP_CHK_J,
        ST_DP_RD_BEST,
        ST_DP_SUM,
        ST_DP_WR,
        ST_DP_FIN_RD,
        ST_DP_FIN,
        ST_OUT
    } t_state;

    function automatic logic [BestW-1:0] sat_add(input logic [BestW-1:0] a,
                                                 input logic [BestW-1:0] b);
        logic [BestW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BestW] ? BestSat : s[BestW-1:0];
    endfunction
endpackage

// ----- hw/rtl/wis_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module wis_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/weighted_interval_scheduling_core.sv -----
// Top level of the weighted interval scheduling core: insertion sort, DP sequencer.
`timescale 1ns / 1ps
// Usage: activities arrive one beat at a time on the input channel (valid/stall).
// Each accepted beat is inserted into an activity memory kept sorted by finish
// minute, equal finishes in arrival order. Insertion walks down from the end of
// the set through the activity memory, one entry at a time, and shifts each
// stored entry with a later finish up one slot (at most 128 entries).
// When the beat marked last has been inserted, the core runs the scheduling
// recurrence over the sorted set. For each entry i it scans backward for the
// latest earlier entry whose finish is at or before the start of i; the scan
// reads the activity memory and the saturating add reads the best-value memory.
// The result beat carries the largest total gain and a flag that items beyond
// 128 were dropped.
// The input stall is high whenever the core is busy; the input port is only
// open in the idle state. The result stays in the output register until the
// receiver drops its stall; no new beat is taken meanwhile.
// After reset the set is empty and the output is not valid. No clearing pass
// is needed since only entries below the fill count are ever read.
module weighted_interval_scheduling_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  wis_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output wis_pkg::t_out_beat o_data
);
    import wis_pkg::*;

    t_state r_state, n_state;

    logic [CountW-1:0]  r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               r_last, n_last;
    t_in_beat           r_item, n_item;
    logic [AddrW-1:0]   r_pos, n_pos;       // insert position / DP index i
    logic [AddrW-1:0]   r_j, n_j;           // DP backward scan index
    logic               r_jv, n_jv;         // scan index still valid
    logic [MinuteW-1:0] r_si, n_si;         // start of entry i
    logic [BestW-1:0]   r_take, n_take;
    logic [BestW-1:0]   r_skip, n_skip;
    t_out_beat          r_out, n_out;
    logic               r_oval, n_oval;

    // Activity memory (start, finish, gain) and best-value memory.
    logic               act_we;
    logic [AddrW-1:0]   act_waddr, act_raddr;
    logic [EntryW-1:0]  act_wdata, act_rdata;
    logic               best_we;
    logic [AddrW-1:0]   best_waddr, best_raddr;
    logic [BestW-1:0]   best_wdata, best_rdata;

    logic [MinuteW-1:0] rd_start, rd_finish;
    logic [GainW-1:0]   rd_gain;
    logic [BestW-1:0]   take_max;

    assign {rd_start, rd_finish, rd_gain} = act_rdata;
    assign take_max = (r_take > r_skip) ? r_take : r_skip;

    wis_ram #(.Width(EntryW), .Depth(MaxItems)) u_act_ram (
        .i_clk  (i_clk),
        .i_we   (act_we),
        .i_waddr(act_waddr),
        .i_wdata(act_wdata),
        .i_raddr(act_raddr),
        .o_rdata(act_rdata)
    );

    wis_ram #(.Width(BestW), .Depth(MaxItems)) u_best_ram (
        .i_clk  (i_clk),
        .i_we   (best_we),
        .i_waddr(best_waddr),
        .i_wdata(best_wdata),
        .i_raddr(best_raddr),
        .o_rdata(best_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_oval  <= n_oval;
        end
        r_last <= n_last;
        r_item <= n_item;
        r_pos  <= n_pos;
        r_j    <= n_j;
        r_jv   <= n_jv;
        r_si   <= n_si;
        r_take <= n_take;
        r_skip <= n_skip;
        r_out  <= n_out;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (r_count == CountW'(MaxItems)) begin
                        n_state = i_data.is_last ? ST_DP_INIT : ST_IDLE;
                    end else if (r_count == '0) begin
                        n_state = ST_INS_CHK;
                    end else begin
                        n_state = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD:  n_state = ST_INS_CHK;
            ST_INS_CHK: begin
                if (r_pos != '0 && rd_finish > r_item.finish_minute && r_jv) begin
                    n_state = ST_INS_RD;
                end else begin
                    n_state = r_last ? ST_DP_INIT : ST_IDLE;
                end
            end
            ST_DP_INIT: n_state = (r_count == '0) ? ST_OUT : ST_DP_RD_I;
            ST_DP_RD_I: n_state = ST_DP_LD_I;
            // Entry 0 has no earlier entry to scan.
            ST_DP_LD_I: n_state = (r_pos != '0) ? ST_DP_RD_J : ST_DP_SUM;
            ST_DP_RD_J: n_state = ST_DP_CHK_J;
            ST_DP_CHK_J: begin
                if (rd_finish <= r_si) begin
                    n_state = ST_DP_RD_BEST;
                end else if (r_j == '0) begin
                    n_state = ST_DP_SUM;
                end else begin
                    n_state = ST_DP_RD_J;
                end
            end
            ST_DP_RD_BEST: n_state = ST_DP_SUM;
            ST_DP_SUM:     n_state = ST_DP_WR;
            ST_DP_WR: begin
                n_state = ({1'b0, r_pos} + 1'b1 == (AddrW + 1)'(r_count))
                          ? ST_DP_FIN_RD : ST_DP_RD_I;
            end
            ST_DP_FIN_RD: n_state = ST_DP_FIN;
            ST_DP_FIN:    n_state = ST_OUT;
            ST_OUT:       n_state = (r_oval && !i_stall) ? ST_IDLE : ST_OUT;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_last     = r_last;
        n_item     = r_item;
        n_pos      = r_pos;
        n_j        = r_j;
        n_jv       = r_jv;
        n_si       = r_si;
        n_take     = r_take;
        n_skip     = r_skip;
        n_out      = r_out;
        n_oval     = r_oval;
        act_we     = 1'b0;
        act_waddr  = r_pos;
        act_wdata  = {r_item.start_minute, r_item.finish_minute, r_item.gain};
        act_raddr  = r_j;
        best_we    = 1'b0;
        best_waddr = r_pos;
        best_wdata = take_max;
        best_raddr = r_j;
        o_stall    = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_item = i_data;
                    n_last = i_data.is_last;
                    if (r_count == CountW'(MaxItems)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_pos   = r_count[AddrW-1:0];
                        n_j     = r_count[AddrW-1:0] - 1'b1;
                        n_jv    = (r_count != '0);
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_INS_RD: begin
                act_raddr = r_j;
            end
            ST_INS_CHK: begin
                if (r_pos != '0 && rd_finish > r_item.finish_minute && r_jv) begin
                    // Shift the later-finishing entry up one slot.
                    act_we    = 1'b1;
                    act_waddr = r_pos;
                    act_wdata = act_rdata;
                    n_pos     = r_pos - 1'b1;
                    n_j       = r_j - 1'b1;
                    n_jv      = (r_j != '0);
                end else begin
                    act_we = 1'b1;
                end
            end
            ST_DP_INIT: begin
                n_pos  = '0;
                n_skip = '0;
            end
            ST_DP_RD_I: begin
                act_raddr = r_pos;
            end
            ST_DP_LD_I: begin
                n_si   = rd_start;
                n_take = BestW'(rd_gain);
                n_j    = r_pos - 1'b1;
                n_jv   = (r_pos != '0);
            end
            ST_DP_RD_J: begin
                act_raddr = r_j;
            end
            ST_DP_CHK_J: begin
                best_raddr = r_j;
                if (!(rd_finish <= r_si) && r_j != '0) begin
                    n_j = r_j - 1'b1;
                end
            end
            ST_DP_RD_BEST: begin
                n_take = sat_add(r_take, best_rdata);
            end
            ST_DP_SUM: begin
                // take vs skip compared through take_max in the write cycle.
            end
            ST_DP_WR: begin
                best_we    = 1'b1;
                best_waddr = r_pos;
                best_wdata = take_max;
                n_skip     = take_max;
                n_pos      = r_pos + 1'b1;
            end
            ST_DP_FIN_RD: begin
                best_raddr = r_count[AddrW-1:0] - 1'b1;
            end
            ST_DP_FIN: begin
                n_out.max_gain = r_skip;
                n_out.dropped  = r_ovf;
                n_oval         = 1'b1;
            end
            ST_OUT: begin
                if (r_state == ST_OUT && (r_count == '0) && !r_oval) begin
                    n_out.max_gain = '0;
                    n_out.dropped  = r_ovf;
                    n_oval         = 1'b1;
                end else if (r_oval && !i_stall) begin
                    n_oval  = 1'b0;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_oval;
    assign o_data  = r_out;

`ifndef SYNTH
    a_out_only_in_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> r_state == ST_OUT)
        else $error("result valid outside output state");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(MaxItems))
        else $error("fill count beyond capacity");
    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !i_stall) |=> (r_count == '0 && !r_ovf && !r_oval))
        else $error("set not cleared after result");
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("input open while busy");
`endif
endmodule

// ----- tb/weighted_interval_scheduling_checker.sv -----
// Checker for the interval scheduling core: predicts each set's result and compares it.
`timescale 1ns / 1ps
module weighted_interval_scheduling_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  wis_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  wis_pkg::t_out_beat i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import wis_pkg::*;

    logic [MinuteW-1:0] act_start  [MaxItems];
    logic [MinuteW-1:0] act_finish [MaxItems];
    logic [GainW-1:0]   act_gain   [MaxItems];
    logic [BestW-1:0]   act_best   [MaxItems];
    int                 act_count;
    logic               act_dropped;
    t_out_beat          schedule_q [$];

    function automatic logic [BestW-1:0] clamp_sum(input logic [BestW-1:0] a,
                                                   input logic [BestW-1:0] b);
        logic [BestW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BestW] ? {BestW{1'b1}} : s[BestW-1:0];
    endfunction

    // Sorted insertion by finish minute; equal finishes keep arrival order.
    task automatic store_activity(input t_in_beat b);
        int pos;
        pos = act_count;
        while (pos > 0 && act_finish[pos-1] > b.finish_minute) begin
            act_start[pos]  = act_start[pos-1];
            act_finish[pos] = act_finish[pos-1];
            act_gain[pos]   = act_gain[pos-1];
            pos--;
        end
        act_start[pos]  = b.start_minute;
        act_finish[pos] = b.finish_minute;
        act_gain[pos]   = b.gain;
        act_count++;
    endtask

    function automatic logic [BestW-1:0] best_schedule_gain();
        logic [BestW-1:0] take;
        logic [BestW-1:0] skip;
        bit               found;
        if (act_count == 0) return '0;
        act_best[0] = BestW'(act_gain[0]);
        for (int i = 1; i < act_count; i++) begin
            skip  = act_best[i-1];
            take  = BestW'(act_gain[i]);
            found = 0;
            for (int j = i - 1; j >= 0 && !found; j--) begin
                if (act_finish[j] <= act_start[i]) begin
                    take  = clamp_sum(take, act_best[j]);
                    found = 1;
                end
            end
            act_best[i] = (take > skip) ? take : skip;
        end
        return act_best[act_count-1];
    endfunction

    assign o_pending = schedule_q.size();

    always @(posedge i_clk) begin
        t_out_beat want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            act_count    = 0;
            act_dropped  = 0;
            o_fail_count <= 0;
            schedule_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (act_count < MaxItems) store_activity(i_in_data);
                else act_dropped = 1;
                if (i_in_data.is_last) begin
                    want.max_gain = best_schedule_gain();
                    want.dropped  = act_dropped;
                    schedule_q.push_back(want);
                    act_count   = 0;
                    act_dropped = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (schedule_q.size() == 0) begin
                    $error("result beat with no set outstanding: max_gain %0d",
                           i_out_data.max_gain);
                    errs++;
                end else begin
                    want = schedule_q.pop_front();
                    if (i_out_data.max_gain !== want.max_gain) begin
                        $error("max_gain: expected %0d, got %0d",
                               want.max_gain, i_out_data.max_gain);
                        errs++;
                    end
                    if (i_out_data.dropped !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d",
                               want.dropped, i_out_data.dropped);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

// ----- tb/tb_weighted_interval_scheduling_core.sv -----
// Testbench top: drives activity sets into the scheduling core and gives the verdict.
`timescale 1ns / 1ps
module tb_weighted_interval_scheduling_core;
    import wis_pkg::*;

    // The watchdog limit covers a full 128-entry DP pass plus the long receiver
    // hold-off, several times over.
    localparam int WatchdogLimit = 400000;
    localparam int LongHold      = 3000;
    localparam int ItemTarget    = 1800;
    localparam int MaxMinute     = 1439;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_data;
    int        fail_count;
    int        sets_pending;

    // Random idling is on for most of the run and switched off near the end.
    bit        gaps_on;
    bit        long_hold_req;
    int        items_sent;
    int        quiet_cycles;

    weighted_interval_scheduling_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    weighted_interval_scheduling_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .o_fail_count(fail_count),
        .o_pending   (sets_pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request so the
    // core parks a result and keeps its input stalled.
    initial begin
        bit hold_done;
        hold_done = 0;
        i_stall = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_req && !hold_done) begin
                i_stall <= 1'b1;
                repeat (LongHold) @(posedge i_clk);
                hold_done = 1;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Valid is left high after a beat goes through so that back-to-back beats
    // never lower and raise it in one step; lower_valid is called before any wait.
    task automatic lower_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_beat(input int s, input int f, input int g, input bit last);
        t_in_beat b;
        b.start_minute  = MinuteW'(s);
        b.finish_minute = MinuteW'(f);
        b.gain          = GainW'(g);
        b.is_last       = last;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // One random set. Narrow windows make many ties and overlaps.
    task automatic send_random_set(input int n);
        int span;
        int s;
        int f;
        span = ($urandom_range(0, 2) == 0) ? 30 : MaxMinute;
        for (int k = 0; k < n; k++) begin
            s = int'($urandom_range(0, span));
            f = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, span))
                                            : s + int'($urandom_range(0, 60));
            if (f > MaxMinute) f = MaxMinute;
            send_beat(s, f, int'($urandom_range(0, 65535)), k == n - 1);
        end
    endtask

    task automatic wait_drained();
        while (sets_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int set_no;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        gaps_on       = 0;
        long_hold_req = 0;
        items_sent    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets: single activities at the extremes of the minute range and gain field.
        send_beat(0, 0, 0, 1);
        send_beat(MaxMinute, MaxMinute, 65535, 1);
        // Start after finish is stored as given.
        send_beat(900, 100, 500, 0);
        send_beat(100, 900, 400, 1);
        // Equal finishes, a chain that touches at the boundary, and overlaps.
        send_beat(0, 60, 10, 0);
        send_beat(30, 60, 20, 0);
        send_beat(60, 120, 30, 0);
        send_beat(120, 180, 40, 0);
        send_beat(50, 170, 95, 1);
        // Compatible full-gain activities in reverse finish order.
        for (int k = 5; k >= 0; k--)
            send_beat(k * 200, k * 200 + 199, 65535, k == 0);
        // A set of exactly 128 and one that overflows, the overflow beat last.
        for (int k = 0; k < MaxItems; k++)
            send_beat(k * 11, k * 11 + 11, 65535, k == MaxItems - 1);
        for (int k = 0; k <= MaxItems; k++)
            send_beat(int'($urandom_range(0, MaxMinute)),
                      int'($urandom_range(0, MaxMinute)),
                      int'($urandom_range(0, 65535)), k == MaxItems);

        // Sender pause until every result is back.
        lower_valid();
        wait_drained();

        gaps_on = 1;
        set_no  = 0;
        while (items_sent < ItemTarget) begin
            if (items_sent > ItemTarget - 250) gaps_on = 0;
            if (set_no == 20) begin
                long_hold_req = 1;
                send_random_set(3);
                send_random_set(4);
                send_random_set(5);
            end else if (set_no == 60) begin
                lower_valid();
                wait_drained();
            end else if (set_no % 70 == 35) begin
                send_random_set($urandom_range(MaxItems - 2, MaxItems + 6));
            end else begin
                send_random_set($urandom_range(1, 10));
            end
            set_no++;
        end

        lower_valid();
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/wis_pkg.sv
hw/rtl/wis_ram.sv
hw/rtl/weighted_interval_scheduling_core.sv
tb/weighted_interval_scheduling_checker.sv
tb/tb_weighted_interval_scheduling_core.sv
